@@ hdl/sha1d_pkg.sv @@
// sha1d_pkg: shared types, constants and command/status structs for the SHA-1 digest unit.
// No dependencies; compiled first.
package sha1d_pkg;

    localparam int unsigned CHAIN_WORDS = 5;

    typedef logic [31:0]                   t_word;
    typedef logic [CHAIN_WORDS-1:0][31:0]  t_chain;   // index 0 is H0
    typedef logic [5:0]                    t_pos;     // byte position in the block
    typedef logic [6:0]                    t_round;
    typedef logic [2:0]                    t_widx;

    localparam t_chain CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam t_round ROUND_SCHED = 7'd16;
    localparam t_round ROUND_20    = 7'd20;
    localparam t_round ROUND_40    = 7'd40;
    localparam t_round ROUND_60    = 7'd60;
    localparam t_round ROUND_LAST  = 7'd79;

    localparam t_pos       POS_LAST  = 6'd63;
    localparam t_pos       POS_LEN   = 6'd56;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam t_widx      WORD_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_MARK,
        AFT_PAD,
        AFT_OUT
    } t_after;

    typedef enum logic [1:0] {
        SH_MSG,
        SH_MARK,
        SH_ZERO,
        SH_LEN
    } t_shsel;

    typedef struct packed {
        logic   shift_en;
        t_shsel shift_sel;
        logic   load_work;
        logic   round_en;
        t_round round;
        logic   fold;
        logic   clear;
    } t_dp_cmd;

    typedef struct packed {
        t_pos pos;
    } t_dp_sts;

endpackage

@@ hdl/sha1d_if.sv @@
// sha1d_if: valid/ready channel interfaces for message bytes in and digest words out.
// Depends on sha1d_pkg for the digest word types.
interface sha1d_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;

    modport source (output valid, data_byte, byte_present, last_byte, input ready);
    modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface sha1d_word_if import sha1d_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word digest_word;
    t_widx word_index;
    logic  last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hdl/sha1d_dpath.sv @@
// sha1d_dpath: block shift buffer, message schedule, round logic, chaining words, byte count.
// Depends on sha1d_pkg; driven by sha1d_ctrl commands.
module sha1d_dpath import sha1d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_data_byte,
    output t_dp_sts    o_sts,
    output t_chain     o_chain
);

    logic [511:0] r_blk;     // word j at [511-32j -: 32], word 0 oldest
    t_chain       r_work;    // a..e at index 0..4
    t_chain       r_chain;
    logic [60:0]  r_cnt;
    t_pos         r_pos;

    t_word       w0, w2, w8, w13, sched, w_t, f, k, a, b, c, d, e, t_sum;
    logic [63:0] len_bits;
    logic [7:0]  len_byte, sh_byte;

    assign w0  = r_blk[511:480];
    assign w2  = r_blk[447:416];
    assign w8  = r_blk[255:224];
    assign w13 = r_blk[95:64];

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];
    assign e = r_work[4];

    assign sched = w13 ^ w8 ^ w2 ^ w0;
    assign w_t   = (i_cmd.round < ROUND_SCHED) ? w0 : {sched[30:0], sched[31]};

    always_comb begin
        if (i_cmd.round < ROUND_20) begin
            f = (b & c) | (~b & d);
            k = K_0;
        end else if (i_cmd.round < ROUND_40) begin
            f = b ^ c ^ d;
            k = K_1;
        end else if (i_cmd.round < ROUND_60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
        end else begin
            f = b ^ c ^ d;
            k = K_3;
        end
    end

    assign t_sum = {a[26:0], a[31:27]} + f + e + k + w_t;

    // length bytes go out big-endian while pos runs 56..63
    assign len_bits = {r_cnt, 3'b000};
    assign len_byte = len_bits[{~r_pos[2:0], 3'b111} -: 8];

    always_comb begin
        case (i_cmd.shift_sel)
            SH_MSG:  sh_byte = i_data_byte;
            SH_MARK: sh_byte = PAD_MARK;
            SH_ZERO: sh_byte = 8'h00;
            SH_LEN:  sh_byte = len_byte;
            default: sh_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= CHAIN_INIT;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else if (i_cmd.clear) begin
            r_chain <= CHAIN_INIT;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int i = 0; i < CHAIN_WORDS; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
            if (i_cmd.shift_en) begin
                r_pos <= r_pos + 6'd1;
                if (i_cmd.shift_sel == SH_MSG) begin
                    r_cnt <= r_cnt + 61'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_blk <= {r_blk[503:0], sh_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_t};
        end
        if (i_cmd.load_work) begin
            r_work <= r_chain;
        end else if (i_cmd.round_en) begin
            r_work <= {d, c, {b[1:0], b[31:2]}, a, t_sum};
        end
    end

    assign o_sts.pos = r_pos;
    assign o_chain   = r_chain;

endmodule

@@ hdl/sha1d_ctrl.sv @@
// sha1d_ctrl: sequencer for byte intake, padding, the 80 rounds and digest hand-off.
// Depends on sha1d_pkg; drives sha1d_dpath and the output stage.
module sha1d_ctrl import sha1d_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_byte_present,
    input  logic    i_last_byte,
    input  t_dp_sts i_sts,
    input  logic    i_out_busy,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    output logic    o_dig_load
);

    t_state r_state, n_state;
    t_round r_rnd, n_rnd;
    t_after r_after, n_after;
    logic   r_len_ok, n_len_ok;
    logic   in_acc, pos_last, pos_len;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign pos_last = (i_sts.pos == POS_LAST);
    assign pos_len  = (i_sts.pos >= POS_LEN);

    always_comb begin
        n_state  = r_state;
        n_rnd    = r_rnd;
        n_after  = r_after;
        n_len_ok = r_len_ok;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present && pos_last) begin
                        n_state = ST_ROUND;
                        n_after = i_last_byte ? AFT_MARK : AFT_IDLE;
                    end else if (i_last_byte) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (pos_last) begin
                    n_state  = ST_ROUND;
                    n_after  = AFT_PAD;
                    n_len_ok = 1'b1;
                end else begin
                    n_state  = ST_PAD;
                    n_len_ok = !pos_len;
                end
            end
            ST_PAD: begin
                if (pos_last) begin
                    n_state  = ST_ROUND;
                    n_after  = r_len_ok ? AFT_OUT : AFT_PAD;
                    n_len_ok = 1'b1;
                end
            end
            ST_ROUND: begin
                if (r_rnd == ROUND_LAST) begin
                    n_state = ST_FOLD;
                    n_rnd   = '0;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            ST_FOLD: begin
                case (r_after)
                    AFT_IDLE: n_state = ST_IDLE;
                    AFT_MARK: n_state = ST_MARK;
                    AFT_PAD:  n_state = ST_PAD;
                    AFT_OUT:  n_state = ST_DONE;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_state  = ST_IDLE;
                    n_len_ok = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_dig_load      = 1'b0;
        o_cmd           = '0;
        o_cmd.shift_sel = SH_ZERO;
        o_cmd.round     = r_rnd;
        // work regs track the chain whenever no round is running
        o_cmd.load_work = (r_state != ST_ROUND);
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.shift_en  = in_acc && i_byte_present;
                o_cmd.shift_sel = SH_MSG;
            end
            ST_MARK: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.shift_sel = SH_MARK;
            end
            ST_PAD: begin
                o_cmd.shift_en  = 1'b1;
                o_cmd.shift_sel = (r_len_ok && pos_len) ? SH_LEN : SH_ZERO;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
            end
            ST_DONE: begin
                o_dig_load  = !i_out_busy;
                o_cmd.clear = !i_out_busy;
            end
            default: begin
                o_cmd.load_work = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rnd    <= '0;
            r_after  <= AFT_IDLE;
            r_len_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rnd    <= n_rnd;
            r_after  <= n_after;
            r_len_ok <= n_len_ok;
        end
    end

endmodule

@@ hdl/sha1d_ostage.sv @@
// sha1d_ostage: digest holding register, streams five words on the output channel.
// Depends on sha1d_pkg and sha1d_word_if.
module sha1d_ostage import sha1d_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_chain i_chain,
    output logic   o_busy,
    sha1d_word_if.source o_out
);

    t_chain r_dig;
    t_widx  r_idx;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && o_out.ready) begin
            if (r_idx == WORD_LAST) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dig <= i_chain;
        end
    end

    assign o_busy            = r_busy;
    assign o_out.valid       = r_busy;
    assign o_out.digest_word = r_dig[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == WORD_LAST);

endmodule

@@ hdl/sha1_digest_unit.sv @@
// sha1_digest_unit: SHA-1 digest of a byte-streamed message, top level.
// Depends on sha1d_pkg, sha1d_if, sha1d_ctrl, sha1d_dpath, sha1d_ostage.
//
//  channel   dir  request carries                        handshake
//  i_in      in   data_byte, byte_present, last_byte    valid/ready
//  o_out     out  digest_word, word_index, last_word    valid/ready
//
// A byte request is taken while the sequencer is idle. Every 64th byte starts a
// compression: the single round unit works through all rounds, then a fold step
// adds the working words into the chaining words; intake waits meanwhile.
// A final request adds a marker byte, fill up to the block end, one or two
// compressions and a hand-off step before the digest appears.
// Reset is synchronous, active low; no clearing pass is needed.
// The five digest words drain from their own register, so the next message
// is taken while a digest is still being read; a second digest waits for it.
module sha1_digest_unit import sha1d_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sha1d_byte_if.sink   i_in,
    sha1d_word_if.source o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_chain  chain;
    logic    dig_load;
    logic    out_busy;
    logic    in_ready;

    assign i_in.ready = in_ready;

    // sequencer: byte intake, padding, round count, digest hand-off
    sha1d_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_byte_present (i_in.byte_present),
        .i_last_byte    (i_in.last_byte),
        .i_sts          (dp_sts),
        .i_out_busy     (out_busy),
        .o_in_ready     (in_ready),
        .o_cmd          (dp_cmd),
        .o_dig_load     (dig_load)
    );

    // block buffer doubles as the 16-word schedule window
    sha1d_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_data_byte (i_in.data_byte),
        .o_sts       (dp_sts),
        .o_chain     (chain)
    );

    sha1d_ostage u_ostage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dig_load),
        .i_chain (chain),
        .o_busy  (out_busy),
        .o_out   (o_out)
    );

    // a new digest never overwrites one still being read out
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dig_load |-> !out_busy)
        else $error("digest loaded while output busy");

    // the end of a message always starts padding or compression work, so intake stops
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_byte) |=> !i_in.ready)
        else $error("input taken straight after final request");

    // after the fifth word the channel goes quiet
    a_out_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> !o_out.valid)
        else $error("output still valid after last word");

    // rounds and byte shifts never share a cycle
    a_shift_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.shift_en && dp_cmd.round_en))
        else $error("byte shift during round");

endmodule
